// ===== hdl/indexed_binary_min_heap_defines.svh =====
// assertion macros for the indexed binary min-heap
// used by files that assert; expects clk_i and rst_ni in scope
`ifndef INDEXED_BINARY_MIN_HEAP_DEFINES_SVH
`define INDEXED_BINARY_MIN_HEAP_DEFINES_SVH

// implication checked on every rising edge outside reset
`define IBH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must hold on every rising edge outside reset
`define IBH_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

`endif

// ===== hdl/ibh_pkg.sv =====
// shared types, constants and helpers of the indexed binary min-heap
// no dependencies
package ibh_pkg;

  localparam int CAPACITY  = 64;
  localparam int ID_COUNT  = 64;
  localparam int KEY_BITS  = 16;
  localparam int ID_BITS   = 6;
  localparam int SLOT_BITS = $clog2(CAPACITY + 1);
  localparam int IDX_BITS  = $clog2(CAPACITY);
  localparam int PID_BITS  = $clog2(ID_COUNT);

  typedef enum logic [1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_UPDATE = 2'd2,
    ACT_REMOVE = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BAD_ID = 2'd3
  } status_e;

  typedef struct packed {
    logic [ID_BITS-1:0]  id;
    logic [KEY_BITS-1:0] key;
  } entry_t;

  typedef struct packed {
    logic                 en;
    logic [PID_BITS-1:0]  addr;
    logic [SLOT_BITS-1:0] data;
  } pos_wr_t;

  localparam int ENTRY_BITS = $bits(entry_t);

  // heap slots are 1-based, storage is 0-based
  function automatic logic [IDX_BITS-1:0] slot2idx(input logic [SLOT_BITS-1:0] s);
    logic [SLOT_BITS-1:0] t;
    t = s - SLOT_BITS'(1);
    return t[IDX_BITS-1:0];
  endfunction

endpackage

// ===== hdl/ibh_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module ibh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/ibh_pos_map.sv =====
// id to heap slot map: ram for the slot, flip-flop valid bits cleared by reset
// depends on ibh_pkg
module ibh_pos_map (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ibh_pkg::pos_wr_t              wr_i,
  input  logic                          re_i,
  input  logic [ibh_pkg::PID_BITS-1:0]  raddr_i,
  output logic [ibh_pkg::SLOT_BITS-1:0] rdata_o
);
  import ibh_pkg::*;

  logic [SLOT_BITS-1:0] mem [ID_COUNT];
  logic [ID_COUNT-1:0]  valid_q;
  logic [SLOT_BITS-1:0] rdata_q;
  logic                 rvalid_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.addr] <= (wr_i.data != '0);
      end
      if (re_i) begin
        rvalid_q <= valid_q[raddr_i];
      end
    end
  end

  // an absent id reads as slot zero
  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

// ===== hdl/indexed_binary_min_heap.sv =====
// indexed binary min-heap: one action per transfer, one result per action
// sequence: flagged actions pass look, place and top; the other actions also settle the entry,
// rising one level per parent read and sinking through sink0, dnl and dnr per level (heap ram has one read port)
// throughput: one action at a time, next accepted the cycle after the result is registered
// reset: count and position valid bits clear at once, no clearing pass
// heap slots are undefined until written; the top fetch reads slot one but uses it only when count is nonzero
module indexed_binary_min_heap (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   action_i,
  input  logic [ibh_pkg::ID_BITS-1:0]  elem_id_i,
  input  logic [ibh_pkg::KEY_BITS-1:0] key_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   status_o,
  output logic [ibh_pkg::ID_BITS-1:0]  out_id_o,
  output logic [ibh_pkg::KEY_BITS-1:0] out_key_o,
  output logic [6:0]                   count_o,
  output logic                         top_valid_o,
  output logic [ibh_pkg::ID_BITS-1:0]  top_id_o,
  output logic [ibh_pkg::KEY_BITS-1:0] top_key_o
);
  import ibh_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE    = 12'b000000000001,
    S_LOOK    = 12'b000000000010,
    S_POP1    = 12'b000000000100,
    S_POPLAST = 12'b000000001000,
    S_REMLAST = 12'b000000010000,
    S_SETTLE  = 12'b000000100000,
    S_PAR     = 12'b000001000000,
    S_SINK0   = 12'b000010000000,
    S_DNL     = 12'b000100000000,
    S_DNR     = 12'b001000000000,
    S_PLACE   = 12'b010000000000,
    S_TOP     = 12'b100000000000
  } state_e;

  state_e               state_q, state_d;
  action_e              act_q, act_d;
  logic [ID_BITS-1:0]   id_q, id_d;
  logic [KEY_BITS-1:0]  key_q, key_d;
  logic [SLOT_BITS-1:0] cnt_q, cnt_d;
  logic [SLOT_BITS-1:0] at_q, at_d;
  entry_t               mov_q, mov_d;
  entry_t               left_q, left_d;
  logic                 rising_q, rising_d;
  logic                 toprd_q, toprd_d;
  status_e              stat_q, stat_d;
  logic [ID_BITS-1:0]   pid_q, pid_d;
  logic [KEY_BITS-1:0]  pkey_q, pkey_d;

  logic                 out_valid_q;
  status_e              o_stat_q;
  logic [ID_BITS-1:0]   o_id_q, o_tid_q;
  logic [KEY_BITS-1:0]  o_key_q, o_tkey_q;
  logic [SLOT_BITS-1:0] o_cnt_q;
  logic                 o_tv_q;

  logic                 heap_we, heap_re;
  logic [SLOT_BITS-1:0] heap_wslot, heap_rslot;
  entry_t               heap_wdata, heap_rdata;
  logic [ENTRY_BITS-1:0] heap_rraw;

  pos_wr_t              pos_wr;
  logic                 pos_re;
  logic [SLOT_BITS-1:0] pos_rdata, pos_eff;

  logic                 in_xfer, load_out;
  logic                 id_ok;
  logic [SLOT_BITS:0]   child, child_r;
  logic [SLOT_BITS-1:0] at_up;
  logic                 top_re_q;

  ibh_ram #(
    .WIDTH(ENTRY_BITS),
    .DEPTH(CAPACITY)
  ) u_heap_ram (
    .clk_i  (clk_i),
    .we_i   (heap_we),
    .waddr_i(slot2idx(heap_wslot)),
    .wdata_i(heap_wdata),
    .re_i   (heap_re),
    .raddr_i(slot2idx(heap_rslot)),
    .rdata_o(heap_rraw)
  );
  assign heap_rdata = entry_t'(heap_rraw);

  ibh_pos_map u_pos_map (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (pos_wr),
    .re_i   (pos_re),
    .raddr_i(elem_id_i[PID_BITS-1:0]),
    .rdata_o(pos_rdata)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign load_out   = !out_valid_q || !out_stall_i;
  assign id_ok      = ({1'b0, id_q} < (ID_BITS+1)'(ID_COUNT));
  assign pos_eff    = (pos_rdata > cnt_q) ? '0 : pos_rdata;
  assign child      = {at_q, 1'b0};
  assign child_r    = child + (SLOT_BITS+1)'(1);
  assign at_up      = at_q >> 1;

  always_comb begin
    state_d    = state_q;
    act_d      = act_q;
    id_d       = id_q;
    key_d      = key_q;
    cnt_d      = cnt_q;
    at_d       = at_q;
    mov_d      = mov_q;
    left_d     = left_q;
    rising_d   = rising_q;
    toprd_d    = 1'b0;
    stat_d     = stat_q;
    pid_d      = pid_q;
    pkey_d     = pkey_q;
    heap_we    = 1'b0;
    heap_wslot = at_q;
    heap_wdata = mov_q;
    heap_re    = 1'b0;
    heap_rslot = SLOT_BITS'(1);
    pos_re     = 1'b0;
    pos_wr     = '0;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          act_d   = action_e'(action_i);
          id_d    = elem_id_i;
          key_d   = key_i;
          stat_d  = ST_OK;
          pid_d   = '0;
          pkey_d  = '0;
          pos_re  = 1'b1;
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        case (act_q)
          ACT_PUSH: begin
            if (!id_ok || pos_eff != '0) begin
              stat_d  = ST_BAD_ID;
              toprd_d = 1'b1;
              state_d = S_PLACE;
            end else if (cnt_q >= SLOT_BITS'(CAPACITY)) begin
              stat_d  = ST_FULL;
              toprd_d = 1'b1;
              state_d = S_PLACE;
            end else begin
              cnt_d   = cnt_q + SLOT_BITS'(1);
              at_d    = cnt_q + SLOT_BITS'(1);
              mov_d   = '{id: id_q, key: key_q};
              state_d = S_SETTLE;
            end
          end
          ACT_POP: begin
            if (cnt_q == '0) begin
              stat_d  = ST_EMPTY;
              toprd_d = 1'b1;
              state_d = S_PLACE;
            end else begin
              heap_re    = 1'b1;
              heap_rslot = SLOT_BITS'(1);
              state_d    = S_POP1;
            end
          end
          ACT_UPDATE: begin
            if (!id_ok || pos_eff == '0) begin
              stat_d  = ST_BAD_ID;
              toprd_d = 1'b1;
              state_d = S_PLACE;
            end else begin
              mov_d   = '{id: id_q, key: key_q};
              at_d    = pos_eff;
              state_d = S_SETTLE;
            end
          end
          default: begin
            if (!id_ok || pos_eff == '0) begin
              stat_d  = ST_BAD_ID;
              toprd_d = 1'b1;
              state_d = S_PLACE;
            end else begin
              pos_wr = '{en: 1'b1, addr: id_q[PID_BITS-1:0], data: '0};
              cnt_d  = cnt_q - SLOT_BITS'(1);
              if (pos_eff == cnt_q) begin
                toprd_d = 1'b1;
                state_d = S_PLACE;
              end else begin
                heap_re    = 1'b1;
                heap_rslot = cnt_q;
                at_d       = pos_eff;
                state_d    = S_REMLAST;
              end
            end
          end
        endcase
      end
      S_POP1: begin
        pid_d      = heap_rdata.id;
        pkey_d     = heap_rdata.key;
        pos_wr     = '{en: 1'b1, addr: heap_rdata.id[PID_BITS-1:0], data: '0};
        heap_re    = 1'b1;
        heap_rslot = cnt_q;
        state_d    = S_POPLAST;
      end
      S_POPLAST: begin
        mov_d = heap_rdata;
        cnt_d = cnt_q - SLOT_BITS'(1);
        if (cnt_q == SLOT_BITS'(1)) begin
          toprd_d = 1'b1;
          state_d = S_PLACE;
        end else begin
          at_d    = SLOT_BITS'(1);
          state_d = S_SETTLE;
        end
      end
      S_REMLAST: begin
        mov_d   = heap_rdata;
        state_d = S_SETTLE;
      end
      S_SETTLE: begin
        rising_d = 1'b0;
        if (at_q > SLOT_BITS'(1)) begin
          heap_re    = 1'b1;
          heap_rslot = at_up;
          state_d    = S_PAR;
        end else begin
          state_d = S_SINK0;
        end
      end
      S_PAR: begin
        // hole moves up: parent drops into the current slot
        if (mov_q.key < heap_rdata.key) begin
          heap_we    = 1'b1;
          heap_wslot = at_q;
          heap_wdata = heap_rdata;
          pos_wr     = '{en: 1'b1, addr: heap_rdata.id[PID_BITS-1:0], data: at_q};
          at_d       = at_up;
          rising_d   = 1'b1;
          if (at_up > SLOT_BITS'(1)) begin
            heap_re    = 1'b1;
            heap_rslot = at_up >> 1;
          end else begin
            state_d = S_PLACE;
          end
        end else if (rising_q) begin
          state_d = S_PLACE;
        end else begin
          state_d = S_SINK0;
        end
      end
      S_SINK0: begin
        if (child <= {1'b0, cnt_q}) begin
          heap_re    = 1'b1;
          heap_rslot = child[SLOT_BITS-1:0];
          state_d    = S_DNL;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_DNL: begin
        left_d = heap_rdata;
        if (child_r <= {1'b0, cnt_q}) begin
          heap_re    = 1'b1;
          heap_rslot = child_r[SLOT_BITS-1:0];
          state_d    = S_DNR;
        end else if (heap_rdata.key < mov_q.key) begin
          heap_we    = 1'b1;
          heap_wdata = heap_rdata;
          pos_wr     = '{en: 1'b1, addr: heap_rdata.id[PID_BITS-1:0], data: at_q};
          at_d       = child[SLOT_BITS-1:0];
          state_d    = S_SINK0;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_DNR: begin
        // left child wins ties
        if (heap_rdata.key < left_q.key) begin
          if (heap_rdata.key < mov_q.key) begin
            heap_we    = 1'b1;
            heap_wdata = heap_rdata;
            pos_wr     = '{en: 1'b1, addr: heap_rdata.id[PID_BITS-1:0], data: at_q};
            at_d       = child_r[SLOT_BITS-1:0];
            state_d    = S_SINK0;
          end else begin
            state_d = S_PLACE;
          end
        end else if (left_q.key < mov_q.key) begin
          heap_we    = 1'b1;
          heap_wdata = left_q;
          pos_wr     = '{en: 1'b1, addr: left_q.id[PID_BITS-1:0], data: at_q};
          at_d       = child[SLOT_BITS-1:0];
          state_d    = S_SINK0;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_PLACE: begin
        // write the moving entry unless arriving only to fetch the top
        if (!toprd_q) begin
          heap_we    = 1'b1;
          heap_wslot = at_q;
          heap_wdata = mov_q;
          pos_wr     = '{en: 1'b1, addr: mov_q.id[PID_BITS-1:0], data: at_q};
        end
        state_d = S_TOP;
      end
      S_TOP: begin
        // while top_re_q is set slot one is fetched, after that the result is loaded when the output is free
        if (top_re_q) begin
          heap_re    = 1'b1;
          heap_rslot = SLOT_BITS'(1);
        end else if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // top fetch issued the cycle after the final write so it sees new data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_re_q <= 1'b0;
    end else begin
      top_re_q <= (state_q == S_PLACE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      rising_q    <= 1'b0;
      toprd_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rising_q <= rising_d;
      toprd_q  <= toprd_d;
      if (state_q == S_TOP && load_out && !top_re_q) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    act_q  <= act_d;
    id_q   <= id_d;
    key_q  <= key_d;
    at_q   <= at_d;
    mov_q  <= mov_d;
    left_q <= left_d;
    stat_q <= stat_d;
    pid_q  <= pid_d;
    pkey_q <= pkey_d;
    if (state_q == S_TOP && load_out && !top_re_q) begin
      o_stat_q <= stat_q;
      o_id_q   <= pid_q;
      o_key_q  <= pkey_q;
      o_cnt_q  <= cnt_q;
      o_tv_q   <= (cnt_q != '0);
      o_tid_q  <= (cnt_q != '0) ? heap_rdata.id : '0;
      o_tkey_q <= (cnt_q != '0) ? heap_rdata.key : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = o_stat_q;
  assign out_id_o    = o_id_q;
  assign out_key_o   = o_key_q;
  assign count_o     = 7'(o_cnt_q);
  assign top_valid_o = o_tv_q;
  assign top_id_o    = o_tid_q;
  assign top_key_o   = o_tkey_q;

  `include "indexed_binary_min_heap_defines.svh"

  `IBH_ASSERT_ALWAYS(a_count_bound, cnt_q <= SLOT_BITS'(CAPACITY), "count above capacity")
  `IBH_ASSERT(a_par_slot, (state_q == S_PAR) |-> (at_q > SLOT_BITS'(1)), "rise at root slot")
  `IBH_ASSERT(a_top_matches_count, out_valid_q |-> (o_tv_q == (o_cnt_q != '0)), "top flag vs count")
  `IBH_ASSERT(a_pop_fields, (out_valid_q && o_stat_q != ST_OK) |-> (o_id_q == '0 && o_key_q == '0), "popped fields on error")

endmodule

// ===== tb/indexed_binary_min_heap_tb.sv =====
// self-checking testbench of the indexed binary min-heap: directed table, fill to capacity, then random actions
// depends on ibh_pkg and indexed_binary_min_heap; keeps its own heap copy to predict results
module indexed_binary_min_heap_tb;
  import ibh_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] action_i = '0;
  logic [ID_BITS-1:0] elem_id_i = '0;
  logic [KEY_BITS-1:0] key_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [1:0] status_o;
  logic [ID_BITS-1:0] out_id_o;
  logic [KEY_BITS-1:0] out_key_o;
  logic [6:0] count_o;
  logic top_valid_o;
  logic [ID_BITS-1:0] top_id_o;
  logic [KEY_BITS-1:0] top_key_o;

  typedef struct packed {
    status_e             status;
    logic [ID_BITS-1:0]  pid;
    logic [KEY_BITS-1:0] pkey;
    logic [6:0]          cnt;
    logic                tvalid;
    logic [ID_BITS-1:0]  tid;
    logic [KEY_BITS-1:0] tkey;
  } heap_result_t;

  typedef struct {
    action_e             act;
    logic [ID_BITS-1:0]  id;
    logic [KEY_BITS-1:0] key;
    bit                  typed;
    heap_result_t        res;
  } stim_row_t;

  indexed_binary_min_heap dut (.*);

  always #2 clk_i = ~clk_i;

  // predictor state
  logic [ID_BITS-1:0]  hp_id [1:CAPACITY];
  logic [KEY_BITS-1:0] hp_key [1:CAPACITY];
  int                  pos_of [ID_COUNT];
  int                  n_entries;

  heap_result_t pending_results[$];
  int  errors;
  int  idle_pct_in, stall_pct_out;
  bit  hold_out;
  int  quiet_cycles;

  function automatic void heap_swap(int a, int b);
    logic [ID_BITS-1:0]  ti;
    logic [KEY_BITS-1:0] tk;
    ti = hp_id[a]; tk = hp_key[a];
    hp_id[a] = hp_id[b]; hp_key[a] = hp_key[b];
    hp_id[b] = ti; hp_key[b] = tk;
    pos_of[hp_id[a]] = a;
    pos_of[hp_id[b]] = b;
  endfunction

  function automatic void sift_up(int at);
    while (at > 1 && hp_key[at] < hp_key[at/2]) begin
      heap_swap(at, at/2);
      at = at/2;
    end
  endfunction

  function automatic void sift_down(int at);
    int l, r, nxt;
    bit has_r;
    while (at*2 <= n_entries) begin
      l = at*2; r = l+1; has_r = r <= n_entries;
      if (hp_key[l] < hp_key[at]) nxt = (has_r && hp_key[r] < hp_key[l]) ? r : l;
      else if (has_r && hp_key[r] < hp_key[at]) nxt = r;
      else break;
      heap_swap(at, nxt);
      at = nxt;
    end
  endfunction

  function automatic void resettle(int at);
    if (at > 1 && hp_key[at] < hp_key[at/2]) sift_up(at);
    else sift_down(at);
  endfunction

  function automatic heap_result_t apply_action(action_e act, logic [ID_BITS-1:0] id,
                                                logic [KEY_BITS-1:0] key);
    heap_result_t r;
    int p;
    r = '0;
    r.status = ST_OK;
    p = pos_of[id];
    case (act)
      ACT_PUSH: begin
        if (p != 0) r.status = ST_BAD_ID;
        else if (n_entries >= CAPACITY) r.status = ST_FULL;
        else begin
          n_entries++;
          hp_id[n_entries] = id; hp_key[n_entries] = key;
          pos_of[id] = n_entries;
          sift_up(n_entries);
        end
      end
      ACT_POP: begin
        if (n_entries == 0) r.status = ST_EMPTY;
        else begin
          r.pid = hp_id[1]; r.pkey = hp_key[1];
          pos_of[hp_id[1]] = 0;
          hp_id[1] = hp_id[n_entries]; hp_key[1] = hp_key[n_entries];
          n_entries--;
          if (n_entries > 0) begin
            pos_of[hp_id[1]] = 1;
            sift_down(1);
          end
        end
      end
      ACT_UPDATE: begin
        if (p == 0) r.status = ST_BAD_ID;
        else begin
          hp_key[p] = key;
          resettle(p);
        end
      end
      default: begin
        if (p == 0) r.status = ST_BAD_ID;
        else begin
          pos_of[id] = 0;
          if (p == n_entries) n_entries--;
          else begin
            hp_id[p] = hp_id[n_entries]; hp_key[p] = hp_key[n_entries];
            n_entries--;
            pos_of[hp_id[p]] = p;
            resettle(p);
          end
        end
      end
    endcase
    r.cnt = 7'(n_entries);
    if (n_entries > 0) begin
      r.tvalid = 1'b1; r.tid = hp_id[1]; r.tkey = hp_key[1];
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // result checking
  always @(posedge clk_i) begin
    heap_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) report_mismatch("unexpected result", 0, 0);
      else begin
        e = pending_results.pop_front();
        if (status_o !== e.status) report_mismatch("status", status_o, e.status);
        if (out_id_o !== e.pid) report_mismatch("out_id", out_id_o, e.pid);
        if (out_key_o !== e.pkey) report_mismatch("out_key", out_key_o, e.pkey);
        if (count_o !== e.cnt) report_mismatch("count", count_o, e.cnt);
        if (top_valid_o !== e.tvalid) report_mismatch("top_valid", top_valid_o, e.tvalid);
        if (top_id_o !== e.tid) report_mismatch("top_id", top_id_o, e.tid);
        if (top_key_o !== e.tkey) report_mismatch("top_key", top_key_o, e.tkey);
      end
    end
  end

  // receiver stalls
  always @(posedge clk_i) begin
    out_stall_i <= hold_out || ($urandom_range(99) < stall_pct_out);
  end

  // watchdog on cycles with no transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_action(action_e act, logic [ID_BITS-1:0] id, logic [KEY_BITS-1:0] key,
                             bit typed, heap_result_t want);
    heap_result_t r;
    while ($urandom_range(99) < idle_pct_in) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act; elem_id_i <= id; key_i <= key;
    do @(posedge clk_i); while (in_stall_o);
    r = apply_action(act, id, key);
    if (typed && r !== want) report_mismatch("directed row vs predictor", 64'(r), 64'(want));
    pending_results.push_back(r);
  endtask

  task automatic send_random();
    action_e act;
    logic [ID_BITS-1:0] id;
    logic [KEY_BITS-1:0] key;
    int sel;
    sel = $urandom_range(99);
    key = ($urandom_range(9) == 0) ? ($urandom_range(1) ? '1 : '0) : KEY_BITS'($urandom);
    id = ID_BITS'($urandom);
    // mostly legal actions on present ids, with some noise
    if (sel < 40) act = ACT_PUSH;
    else if (sel < 60) act = ACT_POP;
    else if (sel < 82) act = ACT_UPDATE;
    else act = ACT_REMOVE;
    if ((act == ACT_UPDATE || act == ACT_REMOVE) && n_entries > 0 && $urandom_range(9) < 8)
      id = hp_id[$urandom_range(n_entries, 1)];
    if (act != ACT_POP && $urandom_range(9) == 0) key = key & 16'h000f;
    send_action(act, id, key, 1'b0, '0);
  endtask

  stim_row_t dir_rows[$];

  function automatic stim_row_t row(action_e a, int id, int key, bit typed = 0,
                                    heap_result_t r = '0);
    stim_row_t s;
    s.act = a; s.id = ID_BITS'(id); s.key = KEY_BITS'(key); s.typed = typed; s.res = r;
    return s;
  endfunction

  initial begin
    errors = 0; idle_pct_in = 0; stall_pct_out = 0; hold_out = 0; quiet_cycles = 0;
    n_entries = 0;
    for (int i = 0; i < ID_COUNT; i++) pos_of[i] = 0;

    dir_rows.push_back(row(ACT_POP, 5, 7, 1, '{ST_EMPTY, 0, 0, 0, 0, 0, 0}));
    dir_rows.push_back(row(ACT_UPDATE, 3, 1, 1, '{ST_BAD_ID, 0, 0, 0, 0, 0, 0}));
    dir_rows.push_back(row(ACT_REMOVE, 63, 0, 1, '{ST_BAD_ID, 0, 0, 0, 0, 0, 0}));
    dir_rows.push_back(row(ACT_PUSH, 63, 'hffff, 1, '{ST_OK, 0, 0, 1, 1, 63, 16'hffff}));
    dir_rows.push_back(row(ACT_PUSH, 63, 5, 1, '{ST_BAD_ID, 0, 0, 1, 1, 63, 16'hffff}));
    dir_rows.push_back(row(ACT_PUSH, 0, 0, 1, '{ST_OK, 0, 0, 2, 1, 0, 0}));
    dir_rows.push_back(row(ACT_PUSH, 10, 0));
    dir_rows.push_back(row(ACT_PUSH, 11, 100));
    dir_rows.push_back(row(ACT_PUSH, 12, 100));
    dir_rows.push_back(row(ACT_PUSH, 13, 50));
    dir_rows.push_back(row(ACT_UPDATE, 63, 1));
    dir_rows.push_back(row(ACT_UPDATE, 0, 'hffff));
    dir_rows.push_back(row(ACT_REMOVE, 13, 'h1234));
    dir_rows.push_back(row(ACT_REMOVE, 12, 0));
    dir_rows.push_back(row(ACT_POP, 42, 'hffff));
    dir_rows.push_back(row(ACT_POP, 0, 0));
    dir_rows.push_back(row(ACT_POP, 0, 0));
    dir_rows.push_back(row(ACT_POP, 0, 0));
    dir_rows.push_back(row(ACT_POP, 0, 0));
    dir_rows.push_back(row(ACT_POP, 0, 0, 1, '{ST_EMPTY, 0, 0, 0, 0, 0, 0}));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_action(dir_rows[i].act, dir_rows[i].id, dir_rows[i].key,
                  dir_rows[i].typed, dir_rows[i].res);

    // fill to capacity under a long receiver hold-off, then push ids already present
    fork
      begin
        hold_out = 1;
        repeat (300) @(posedge clk_i);
        hold_out = 0;
      end
      begin
        for (int i = 0; i < ID_COUNT; i++)
          if (pos_of[i] == 0) send_action(ACT_PUSH, ID_BITS'(i), KEY_BITS'($urandom), 0, '0);
      end
    join
    for (int i = 0; i < 3; i++) send_action(ACT_PUSH, ID_BITS'(i), 16'h1, 0, '0);
    send_action(ACT_REMOVE, 6'd20, 16'h0, 0, '0);
    send_action(ACT_PUSH, 6'd20, 16'h0, 0, '0);
    send_action(ACT_PUSH, 6'd21, 16'h0, 0, '0);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin idle_pct_in = 0;  stall_pct_out = 0;  end
        1: begin idle_pct_in = 55; stall_pct_out = 0;  end
        2: begin idle_pct_in = 0;  stall_pct_out = 55; end
        3: begin idle_pct_in = 27; stall_pct_out = 27; end
        default: begin idle_pct_in = 0; stall_pct_out = 0; end
      endcase
      repeat (64) send_random();
    end
    in_valid_i <= 1'b0;
    idle_pct_in = 0; stall_pct_out = 0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
